@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL; included by the queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/tlpq_pkg.sv @@
// Package for the two-level priority queue: codes, widths and cell control.
`timescale 1ns / 1ps

package tlpq_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // Fixed field widths of the streams
  localparam int ACTION_W     = 2;
  localparam int PRIO_W       = 3;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int ITEM_COUNT_W = 5;

  localparam int IN_FIELDS_W  = ACTION_W + PRIO_W + VALUE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + VALUE_W + 1 + ITEM_COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [ACTION_W-1:0] ACT_ENQ  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;

  localparam logic [PRIO_W-1:0] PRIO_LOW  = 3'd0;
  localparam logic [PRIO_W-1:0] PRIO_HIGH = 3'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BADPRIO = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic ins;       // insert a new entry this cycle
    logic deq;       // shift everything toward the head
    logic ins_high;  // new entry is high priority
  } ctl_t;

endpackage

@@ rtl/tlpq_cell.sv @@
// One slot of the queue chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module tlpq_cell #(
  parameter int IDX        = 0,
  parameter int CNT_W      = 5,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  tlpq_pkg::ctl_t        ctl,
  input  logic [CNT_W-1:0]      cnt,
  input  logic [DATA_WIDTH-1:0] new_data,
  input  logic                  left_stay,
  input  logic                  left_high,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  right_high,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic                  stay,
  output logic                  high_q,
  output logic [DATA_WIDTH-1:0] data_q
);

  import tlpq_pkg::*;

  logic                  high_r;
  logic                  high_nxt;
  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  occupied;

  assign occupied = CNT_W'(IDX) < cnt;
  // Entries ahead of the insert point keep their place
  assign stay     = occupied && (!ctl.ins_high || high_r);
  assign high_q   = high_r;
  assign data_q   = data_r;

  always_comb begin
    high_nxt = high_r;
    data_nxt = data_r;
    if (ctl.deq) begin
      high_nxt = right_high;
      data_nxt = right_data;
    end else if (ctl.ins && !stay) begin
      if (left_stay) begin
        high_nxt = ctl.ins_high;
        data_nxt = new_data;
      end else begin
        high_nxt = left_high;
        data_nxt = left_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins || ctl.deq) begin
      high_r <= high_nxt;
      data_r <= data_nxt;
    end
  end

endmodule

@@ rtl/two_level_priority_queue.sv @@
// Top level of the two-level priority queue: request decode, count and result register.
`timescale 1ns / 1ps

// Two-level priority queue built as a chain of CAPACITY slot cells. Every
// request (enqueue, dequeue or peek) is taken directly: the cells shift the
// whole chain one place when it is accepted, to open a gap or close the
// head, so one request per cycle is accepted whenever the result register is
// free or being emptied in the same cycle. The result appears on the out
// channel in the cycle after acceptance and reports the status, the head
// entry and the count after the request. No clearing pass follows reset.
`include "assert_macros.svh"

module two_level_priority_queue #(
  parameter int CAPACITY   = tlpq_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = tlpq_pkg::DEF_DATA_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] action, [4:2] priority_level, [36:5] item_value, rest zero
  input  logic [tlpq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [33:2] head_value, [34] head_valid, [39:35] item_count
  output logic [tlpq_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import tlpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                  acc;
  logic [ACTION_W-1:0]   in_action;
  logic [PRIO_W-1:0]     in_prio;
  logic [VALUE_W-1:0]    in_value;
  logic [DATA_WIDTH-1:0] new_data;
  status_t               status;
  ctl_t                  ctl;

  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [DATA_WIDTH-1:0] head_nxt;

  logic                  out_tvalid_r;
  status_t               status_r;
  logic [VALUE_W-1:0]    head_value_r;
  logic                  head_valid_r;
  logic [ITEM_COUNT_W-1:0] item_count_r;

  logic                  stay   [CAPACITY];
  logic                  high_q [CAPACITY];
  logic [DATA_WIDTH-1:0] data_q [CAPACITY];

  assign in_action = in_tdata[ACTION_W-1:0];
  assign in_prio   = in_tdata[ACTION_W +: PRIO_W];
  assign in_value  = in_tdata[ACTION_W + PRIO_W +: VALUE_W];
  assign new_data  = DATA_WIDTH'(in_value);

  assign in_tready = !out_tvalid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    status = ST_OK;
    case (in_action)
      ACT_ENQ: begin
        if (in_prio != PRIO_LOW && in_prio != PRIO_HIGH) begin
          status = ST_BADPRIO;
        end else if (cnt_r == CNT_W'(CAPACITY)) begin
          status = ST_FULL;
        end
      end
      default: begin
        if (cnt_r == '0) begin
          status = ST_EMPTY;
        end
      end
    endcase
  end

  assign ctl.ins      = acc && (in_action == ACT_ENQ) && (status == ST_OK);
  assign ctl.deq      = acc && (in_action == ACT_DEQ) && (status == ST_OK);
  assign ctl.ins_high = (in_prio == PRIO_HIGH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.deq) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Head entry after this request
  always_comb begin
    head_nxt = data_q[0];
    if (ctl.deq) begin
      head_nxt = data_q[1];
    end else if (ctl.ins && !stay[0]) begin
      head_nxt = new_data;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_stay;
    logic                  l_high;
    logic [DATA_WIDTH-1:0] l_data;
    logic                  r_high;
    logic [DATA_WIDTH-1:0] r_data;

    if (i == 0) begin : g_first
      // Head cell always sees an open insert point to its left
      assign l_stay = 1'b1;
      assign l_high = 1'b0;
      assign l_data = new_data;
    end else begin : g_mid
      assign l_stay = stay[i-1];
      assign l_high = high_q[i-1];
      assign l_data = data_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_high = 1'b0;
      assign r_data = '0;
    end else begin : g_inner
      assign r_high = high_q[i+1];
      assign r_data = data_q[i+1];
    end

    tlpq_cell #(
      .IDX        (i),
      .CNT_W      (CNT_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cnt        (cnt_r),
      .new_data   (new_data),
      .left_stay  (l_stay),
      .left_high  (l_high),
      .left_data  (l_data),
      .right_high (r_high),
      .right_data (r_data),
      .stay       (stay[i]),
      .high_q     (high_q[i]),
      .data_q     (data_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r        <= cnt_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r     <= status;
      head_valid_r <= (cnt_nxt != '0);
      head_value_r <= (cnt_nxt != '0) ? VALUE_W'(head_nxt) : '0;
      item_count_r <= ITEM_COUNT_W'(cnt_nxt);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'({item_count_r, head_valid_r, head_value_r, status_r});

  `ASSERT_NEVER(a_cnt_max, clk, rst_n, cnt_r > CNT_W'(CAPACITY))
  `ASSERT_CLK(a_deq_count, clk, rst_n,
              ctl.deq |=> cnt_r == $past(cnt_r) - CNT_W'(1))
  `ASSERT_CLK(a_high_head, clk, rst_n, (ctl.ins && ctl.ins_high) |=> high_q[0])
  `ASSERT_CLK(a_head_valid, clk, rst_n,
              out_tvalid_r |-> (head_valid_r == (item_count_r != '0)))

endmodule
